@@ src/hrd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrd_pkg
// Types, constants and helpers shared by the response decoder modules.
// ----------------------------------------------------------------------------
package hrd_pkg;

    localparam int LINE_BYTES   = 256;
    localparam int RETRY_BYTES  = 32;
    localparam int LENGTH_LIMIT = 16384;
    localparam int LEN_W        = $clog2(LINE_BYTES + 1);
    localparam int LEFT_W       = $clog2(LENGTH_LIMIT + 1);

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    localparam logic CFG_HDR_LIMIT = 1'b0;
    localparam logic CFG_BODY_CAP  = 1'b1;

    localparam logic [15:0] HDR_LIMIT_RST = 16'd8192;
    localparam logic [15:0] BODY_CAP_RST  = 16'd16384;

    localparam logic [135:0] LIT_HTTP     = "HTTP/1.1 ";
    localparam logic [135:0] LIT_CL       = "content-length";
    localparam logic [135:0] LIT_TE       = "transfer-encoding";
    localparam logic [135:0] LIT_CE       = "content-encoding";
    localparam logic [135:0] LIT_RA       = "retry-after";
    localparam logic [135:0] LIT_CHUNKED  = "chunked";
    localparam logic [135:0] LIT_IDENTITY = "identity";
    localparam logic [4:0]   LEN_HTTP     = 5'd9;
    localparam logic [4:0]   LEN_CL       = 5'd14;
    localparam logic [4:0]   LEN_TE       = 5'd17;
    localparam logic [4:0]   LEN_CE       = 5'd16;
    localparam logic [4:0]   LEN_RA       = 5'd11;
    localparam logic [4:0]   LEN_CHUNKED  = 5'd7;
    localparam logic [4:0]   LEN_IDENTITY = 5'd8;

    typedef enum logic [3:0] {
        PH_STATUS     = 4'd0,
        PH_HEADERS    = 4'd1,
        PH_CHUNK_SIZE = 4'd2,
        PH_CHUNK_DATA = 4'd3,
        PH_CHUNK_CR   = 4'd4,
        PH_CHUNK_LF   = 4'd5,
        PH_TRAILERS   = 4'd6,
        PH_FIXED      = 4'd7,
        PH_CLOSE      = 4'd8,
        PH_DONE       = 4'd9
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic [7:0] lc;
        logic       is_cr;
        logic       is_lf;
        logic       is_ws;
        logic       is_ctrl;
        logic       is_name;
        logic       is_digit;
        logic [3:0] dval;
        logic       is_hex;
        logic [3:0] hval;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic       full;
    } t_qstat;

    typedef struct packed {
        logic              colon;
        logic              name_bad;
        logic [3:0]        nm;
        logic              val_on;
        logic [LEN_W-1:0]  pend;
        logic [LEN_W-1:0]  vlen;
        logic [1:0]        cl_evt;
        logic [LEFT_W-1:0] cl_acc;
        logic              te_ok;
        logic              ce_ok;
        logic              st_ok;
        logic [9:0]        code;
        logic              semi;
        logic [3:0]        ck_cnt;
        logic [1:0]        ck_evt;
        logic [LEFT_W-1:0] ck_acc;
    } t_line;

    localparam t_line LINE_INIT = '{
        colon: 1'b0, name_bad: 1'b0, nm: 4'b1111, val_on: 1'b0,
        pend: '0, vlen: '0, cl_evt: ERR_NONE, cl_acc: '0,
        te_ok: 1'b1, ce_ok: 1'b1, st_ok: 1'b1, code: '0,
        semi: 1'b0, ck_cnt: '0, ck_evt: ERR_NONE, ck_acc: '0
    };

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic [9:0] status_code;
        logic [1:0] error_code;
        logic       message_done;
        logic       end_ok;
    } t_res;

    // true when c equals character pos of a right-aligned literal of length len
    function automatic logic lit_eq(input logic [135:0] lit, input logic [4:0] len,
                                    input logic [LEN_W-1:0] pos, input logic [7:0] c);
        logic [4:0] k;
        logic [7:0] sel;
        k   = len - pos[4:0] - 5'd1;
        sel = lit[{k, 3'b000} +: 8];
        return (pos < LEN_W'(len)) && (c == sel);
    endfunction

endpackage

@@ src/http_response_decoder_core.sv @@
// ----------------------------------------------------------------------------
// http_response_decoder_core
// Byte-serial HTTP/1.x response decoder with body byte output.
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | data_byte[7:0]                 | op
//  m_axis   | out       | body_byte, status_code,        | body_valid
//           |           | error_code, message_done,      |
//           |           | end_ok                         |
//  i_cfg_*  | in        | 0 header_byte_limit, 1 body_capacity
//
// one item per cycle unless output stalls; items pass the queue, then the result register
// the parser evaluates a whole line in the cycle of its lf byte
// a two-entry queue lets input continue while the output is stalled
// reset is synchronous; limits return to 8192 and 16384 header and body bytes
// ----------------------------------------------------------------------------
module http_response_decoder_core import hrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // body_byte, status_code, error_code, message_done,
                                        // end_ok, zero fill
    output logic [0:0]  m_axis_tuser,   // body_valid
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_hdr_limit;
    logic [15:0] r_body_cap;
    t_qstat      q_stat;
    t_item       f_item;
    t_item       q_item;
    logic        f_push;
    logic        b_pop;
    t_res        b_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_limit <= HDR_LIMIT_RST;
            r_body_cap  <= BODY_CAP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HDR_LIMIT) r_hdr_limit <= i_cfg_data;
            if (i_cfg_idx == CFG_BODY_CAP)  r_body_cap  <= i_cfg_data;
        end
    end

    hrd_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser[0]),
        .i_byte  (s_axis_tdata),
        .i_qstat (q_stat),
        .o_push  (f_push),
        .o_item  (f_item)
    );

    hrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_item  (q_item),
        .o_qstat (q_stat)
    );

    hrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (q_stat),
        .i_item      (q_item),
        .o_pop       (b_pop),
        .i_hdr_limit (r_hdr_limit),
        .i_body_cap  (r_body_cap),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (b_res)
    );

    assign m_axis_tuser = b_res.body_valid;
    assign m_axis_tdata = {2'b00, b_res.end_ok, b_res.message_done, b_res.error_code,
                           b_res.status_code, b_res.body_byte};

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !f_push)
        else $error("item pushed into full queue");

    a_body_without_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[19:18] == ERR_NONE))
        else $error("body item carries an error");

    a_end_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[21]) |-> m_axis_tdata[20])
        else $error("end_ok without message_done");

endmodule

@@ src/hrd_front.sv @@
// ----------------------------------------------------------------------------
// hrd_front
// Accepts input items and classifies the byte for the parser.
// ----------------------------------------------------------------------------
module hrd_front import hrd_pkg::*; (
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_byte,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_item      o_item
);

    logic [7:0] b;
    logic       upper;
    logic       lower;
    logic       digit;

    assign b     = i_byte;
    assign upper = (b >= "A") && (b <= "Z");
    assign lower = (b >= "a") && (b <= "z");
    assign digit = (b >= "0") && (b <= "9");

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_item          = '0;
        o_item.op       = i_op;
        o_item.b        = b;
        o_item.lc       = upper ? (b + 8'd32) : b;
        o_item.is_cr    = (b == 8'h0d);
        o_item.is_lf    = (b == 8'h0a);
        o_item.is_ws    = (b == " ") || (b == 8'h09);
        o_item.is_ctrl  = (b < 8'd32) && (b != 8'h09);
        o_item.is_name  = upper || lower || digit || (b == "-");
        o_item.is_digit = digit;
        o_item.dval     = b[3:0];
        o_item.is_hex   = digit || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
        o_item.hval     = digit ? b[3:0] : (b[3:0] + 4'd9);
    end

endmodule

@@ src/hrd_queue.sv @@
// ----------------------------------------------------------------------------
// hrd_queue
// Two-entry item queue between the front and the parser.
// ----------------------------------------------------------------------------
module hrd_queue import hrd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qstat
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_item        = r_mem[r_rp];
    assign o_qstat.valid = (r_cnt != 2'd0);
    assign o_qstat.full  = (r_cnt == 2'd2);

endmodule

@@ src/hrd_back.sv @@
// ----------------------------------------------------------------------------
// hrd_back
// Response parser: line checks, header actions, body framing, result register.
// ----------------------------------------------------------------------------
module hrd_back import hrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qstat      i_qstat,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [15:0] i_hdr_limit,
    input  logic [15:0] i_body_cap,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);

    t_phase            r_phase, n_phase;
    logic              r_cr, n_cr;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [15:0]       r_hdr, n_hdr;
    logic [15:0]       r_body, n_body;
    logic              r_chunked, n_chunked;
    logic              r_given, n_given;
    logic              r_retry, n_retry;
    logic [9:0]        r_status, n_status;
    logic [1:0]        r_err, n_err;
    t_line             r_ln, n_ln;
    logic              r_out_valid;
    t_res              r_out, n_out;

    t_item             it;
    logic [LEN_W-1:0]  idx;
    logic [1:0]        evt;
    logic [17:0]       dec;
    logic [18:0]       hex;
    logic [LEFT_W-1:0] left_dec;

    assign it    = i_item;
    assign o_pop = i_qstat.valid && (!r_out_valid || i_ready);

    always_comb begin
        n_phase   = r_phase;
        n_cr      = r_cr;
        n_len     = r_len;
        n_left    = r_left;
        n_hdr     = r_hdr;
        n_body    = r_body;
        n_chunked = r_chunked;
        n_given   = r_given;
        n_retry   = r_retry;
        n_status  = r_status;
        n_err     = r_err;
        n_ln      = r_ln;
        n_out     = '0;
        idx       = '0;
        evt       = ERR_NONE;
        dec       = '0;
        hex       = '0;
        left_dec  = '0;
        if (o_pop) begin
            if (it.op) begin
                if (r_err == ERR_NONE) begin
                    if (r_phase == PH_CLOSE) begin
                        n_phase = PH_DONE;
                    end else if (r_phase != PH_DONE) begin
                        n_err = ERR_MALFORMED;
                    end
                end
                n_out.end_ok = (n_phase == PH_DONE) && (n_err == ERR_NONE);
            end else if (r_err == ERR_NONE) begin
                case (r_phase)
                    PH_DONE: begin
                        n_err = ERR_MALFORMED;
                    end
                    PH_FIXED, PH_CLOSE, PH_CHUNK_DATA: begin
                        if (r_body >= i_body_cap) begin
                            n_err = ERR_TOO_LARGE;
                        end else begin
                            n_body           = r_body + 16'd1;
                            n_out.body_valid = 1'b1;
                            n_out.body_byte  = it.b;
                            if (r_phase != PH_CLOSE) begin
                                left_dec = (r_left != '0) ? (r_left - LEFT_W'(1)) : '0;
                                n_left   = left_dec;
                                if (left_dec == '0) begin
                                    n_phase = (r_phase == PH_FIXED) ? PH_DONE : PH_CHUNK_CR;
                                end
                            end
                        end
                    end
                    PH_CHUNK_CR: begin
                        if (!it.is_cr) n_err = ERR_MALFORMED;
                        else n_phase = PH_CHUNK_LF;
                    end
                    PH_CHUNK_LF: begin
                        if (!it.is_lf) n_err = ERR_MALFORMED;
                        else n_phase = PH_CHUNK_SIZE;
                    end
                    default: begin
                        if (r_hdr >= i_hdr_limit) begin
                            n_err = ERR_TOO_LARGE;
                        end else begin
                            n_hdr = r_hdr + 16'd1;
                            if (r_cr) begin
                                if (!it.is_lf) begin
                                    n_err = ERR_MALFORMED;
                                end else begin
                                    n_cr  = 1'b0;
                                    n_len = '0;
                                    n_ln  = LINE_INIT;
                                    if (r_phase == PH_STATUS) begin
                                        if (!r_ln.st_ok || (r_len < LEN_W'(12)) ||
                                            (r_ln.code < 10'd200) || (r_ln.code > 10'd599)) begin
                                            n_err = ERR_MALFORMED;
                                        end else begin
                                            n_status = r_ln.code;
                                            n_phase  = PH_HEADERS;
                                        end
                                    end else if (r_phase == PH_CHUNK_SIZE) begin
                                        if ((r_ln.ck_cnt == 4'd0) || (r_ln.ck_cnt > 4'd8)) begin
                                            n_err = ERR_MALFORMED;
                                        end else if (r_ln.ck_evt != ERR_NONE) begin
                                            n_err = r_ln.ck_evt;
                                        end else begin
                                            n_left  = r_ln.ck_acc;
                                            n_phase = (r_ln.ck_acc != '0) ? PH_CHUNK_DATA
                                                                          : PH_TRAILERS;
                                        end
                                    end else if (r_len == '0) begin
                                        if (r_phase == PH_TRAILERS) n_phase = PH_DONE;
                                        else if (r_chunked && r_given) n_err = ERR_MALFORMED;
                                        else if (r_chunked) n_phase = PH_CHUNK_SIZE;
                                        else if (r_given) begin
                                            n_phase = (r_left != '0) ? PH_FIXED : PH_DONE;
                                        end else n_phase = PH_CLOSE;
                                    end else if (!r_ln.colon || r_ln.name_bad) begin
                                        n_err = ERR_MALFORMED;
                                    end else if (r_phase == PH_HEADERS) begin
                                        if (r_ln.nm[0]) begin
                                            if (r_given || (r_ln.vlen == '0) ||
                                                (r_ln.vlen > LEN_W'(10))) begin
                                                n_err = ERR_MALFORMED;
                                            end else begin
                                                n_given = 1'b1;
                                                if (r_ln.cl_evt != ERR_NONE) n_err = r_ln.cl_evt;
                                                else n_left = r_ln.cl_acc;
                                            end
                                        end else if (r_ln.nm[1]) begin
                                            if (r_chunked || !r_ln.te_ok ||
                                                (r_ln.vlen != LEN_W'(LEN_CHUNKED))) begin
                                                n_err = ERR_MALFORMED;
                                            end else begin
                                                n_chunked = 1'b1;
                                            end
                                        end else if (r_ln.nm[2]) begin
                                            if (!r_ln.ce_ok ||
                                                (r_ln.vlen != LEN_W'(LEN_IDENTITY))) begin
                                                n_err = ERR_MALFORMED;
                                            end
                                        end else if (r_ln.nm[3]) begin
                                            if (r_retry || (r_ln.vlen > LEN_W'(RETRY_BYTES))) begin
                                                n_err = ERR_MALFORMED;
                                            end else begin
                                                n_retry = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end else if (it.is_cr) begin
                                n_cr = 1'b1;
                            end else if (it.is_ctrl || (r_len >= LEN_W'(LINE_BYTES))) begin
                                n_err = ERR_MALFORMED;
                            end else begin
                                n_len = r_len + LEN_W'(1);
                                // status line fields
                                if (r_len < LEN_W'(9)) begin
                                    n_ln.st_ok = r_ln.st_ok &&
                                        (lit_eq(LIT_HTTP, LEN_HTTP, r_len, it.b) ||
                                         ((r_len == LEN_W'(7)) && (it.b == "0")));
                                end else if (r_len < LEN_W'(12)) begin
                                    n_ln.st_ok = r_ln.st_ok && it.is_digit;
                                    n_ln.code  = 10'({r_ln.code, 3'b000}) +
                                                 10'({r_ln.code, 1'b0}) + 10'(it.dval);
                                end else if (r_len == LEN_W'(12)) begin
                                    n_ln.st_ok = r_ln.st_ok && (it.b == " ");
                                end
                                // chunk size
                                if (!r_ln.semi) begin
                                    if (it.b == ";") begin
                                        n_ln.semi = 1'b1;
                                    end else begin
                                        if (r_ln.ck_cnt != 4'd9) n_ln.ck_cnt = r_ln.ck_cnt + 4'd1;
                                        if (r_ln.ck_evt == ERR_NONE) begin
                                            hex = {r_ln.ck_acc, 4'b0000} + 19'(it.hval);
                                            if (!it.is_hex) n_ln.ck_evt = ERR_MALFORMED;
                                            else if (hex > 19'(LENGTH_LIMIT)) begin
                                                n_ln.ck_evt = ERR_TOO_LARGE;
                                            end else n_ln.ck_acc = hex[LEFT_W-1:0];
                                        end
                                    end
                                end
                                // header name and value
                                if (!r_ln.colon) begin
                                    if (it.b == ":") begin
                                        n_ln.colon = 1'b1;
                                        if (r_len == '0) n_ln.name_bad = 1'b1;
                                        n_ln.nm[0] = r_ln.nm[0] && (r_len == LEN_W'(LEN_CL));
                                        n_ln.nm[1] = r_ln.nm[1] && (r_len == LEN_W'(LEN_TE));
                                        n_ln.nm[2] = r_ln.nm[2] && (r_len == LEN_W'(LEN_CE));
                                        n_ln.nm[3] = r_ln.nm[3] && (r_len == LEN_W'(LEN_RA));
                                    end else begin
                                        if (!it.is_name) n_ln.name_bad = 1'b1;
                                        n_ln.nm[0] = r_ln.nm[0] && lit_eq(LIT_CL, LEN_CL, r_len, it.lc);
                                        n_ln.nm[1] = r_ln.nm[1] && lit_eq(LIT_TE, LEN_TE, r_len, it.lc);
                                        n_ln.nm[2] = r_ln.nm[2] && lit_eq(LIT_CE, LEN_CE, r_len, it.lc);
                                        n_ln.nm[3] = r_ln.nm[3] && lit_eq(LIT_RA, LEN_RA, r_len, it.lc);
                                    end
                                end else if (it.is_ws) begin
                                    if (r_ln.val_on) n_ln.pend = r_ln.pend + LEN_W'(1);
                                end else begin
                                    idx = r_ln.vlen + r_ln.pend;
                                    evt = r_ln.cl_evt;
                                    if (r_ln.pend != '0) begin
                                        n_ln.te_ok = 1'b0;
                                        n_ln.ce_ok = 1'b0;
                                        if (evt == ERR_NONE) evt = ERR_MALFORMED;
                                    end
                                    n_ln.te_ok = n_ln.te_ok &&
                                                 lit_eq(LIT_CHUNKED, LEN_CHUNKED, idx, it.b);
                                    n_ln.ce_ok = n_ln.ce_ok &&
                                                 lit_eq(LIT_IDENTITY, LEN_IDENTITY, idx, it.b);
                                    if (evt == ERR_NONE) begin
                                        dec = 18'(r_ln.cl_acc) * 18'd10 + 18'(it.dval);
                                        if (!it.is_digit) evt = ERR_MALFORMED;
                                        else if (dec > 18'(LENGTH_LIMIT)) evt = ERR_TOO_LARGE;
                                        else n_ln.cl_acc = dec[LEFT_W-1:0];
                                    end
                                    n_ln.cl_evt = evt;
                                    n_ln.vlen   = idx + LEN_W'(1);
                                    n_ln.pend   = '0;
                                    n_ln.val_on = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
        end
        n_out.status_code  = n_status;
        n_out.error_code   = n_err;
        n_out.message_done = (n_phase == PH_DONE) && (n_err == ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STATUS;
            r_cr        <= 1'b0;
            r_len       <= '0;
            r_left      <= '0;
            r_hdr       <= '0;
            r_body      <= '0;
            r_chunked   <= 1'b0;
            r_given     <= 1'b0;
            r_retry     <= 1'b0;
            r_status    <= '0;
            r_err       <= ERR_NONE;
            r_ln        <= LINE_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_cr      <= n_cr;
                r_len     <= n_len;
                r_left    <= n_left;
                r_hdr     <= n_hdr;
                r_body    <= n_body;
                r_chunked <= n_chunked;
                r_given   <= n_given;
                r_retry   <= n_retry;
                r_status  <= n_status;
                r_err     <= n_err;
                r_ln      <= n_ln;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
